// ----- hw/rtl/stanley_pkg.sv -----
// Shared types and constants for the Stanley steering law pipeline.
`timescale 1ns / 1ps
`default_nettype none

package stanley_pkg;

    // CORDIC datapath widths: magnitudes stay below 2^32 after gain growth
    localparam int X_W = 34;
    localparam int Z_W = 20;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_GAIN  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT = 4'd1;

    localparam logic [15:0] GAIN_RESET  = 16'd2048;
    localparam logic [13:0] LIMIT_RESET = 14'd9175;

    // 0.1 m/s in Q8.8 and pi/2 in Q3.13
    localparam logic signed [15:0] SPEED_FLOOR = 16'sd26;
    localparam logic signed [Z_W-1:0] HALF_PI_Q13 = 20'sd12868;

    localparam int ATAN_LEN = 20;

    // atan(2^-i) in radians * 2^16
    localparam logic [16:0] ATAN_Q16 [0:ATAN_LEN-1] = '{
        17'd51472, 17'd30385, 17'd16055, 17'd8150, 17'd4091,
        17'd2047,  17'd1024,  17'd512,   17'd256,  17'd128,
        17'd64,    17'd32,    17'd16,    17'd8,    17'd4,
        17'd2,     17'd1,     17'd0,     17'd0,    17'd0
    };

    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic signed [X_W-1:0] y;
        logic signed [Z_W-1:0] z;
        logic                  neg;
        logic                  zero;
        logic signed [15:0]    head;
    } cordic_t;

endpackage

`default_nettype wire

// ----- hw/rtl/stanley_prep.sv -----
// Front end: speed floor, gain multiply, then numerator magnitude and sign.
`timescale 1ns / 1ps
`default_nettype none

module stanley_prep
    import stanley_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [15:0]        gain,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] heading_error,
    input  wire logic signed [15:0] lateral_error,
    input  wire logic signed [15:0] vehicle_speed,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output cordic_t                 out_data
);

    logic                  a_valid_reg;
    logic                  a_ready;
    logic signed [32:0]    prod_reg;
    logic signed [32:0]    prod_next;
    logic signed [15:0]    spd_reg;
    logic signed [15:0]    spd_next;
    logic signed [15:0]    head_reg;
    logic                  b_valid_reg;
    logic                  b_ready;
    cordic_t               b_data_reg;
    cordic_t               b_data_next;
    logic signed [16:0]    gain_s;
    logic signed [32:0]    mag;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb
    begin
        gain_s    = $signed({1'b0, gain});
        prod_next = 33'(gain_s) * 33'(lateral_error);
        spd_next  = (vehicle_speed < SPEED_FLOOR) ? SPEED_FLOOR : vehicle_speed;
    end

    always_comb
    begin
        mag              = prod_reg[32] ? -prod_reg : prod_reg;
        b_data_next.x    = {{(X_W-28){spd_reg[15]}}, spd_reg, 12'd0};
        b_data_next.y    = {{(X_W-33){mag[32]}}, mag};
        b_data_next.z    = '0;
        b_data_next.neg  = prod_reg[32];
        b_data_next.zero = (prod_reg == '0);
        b_data_next.head = head_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            prod_reg <= prod_next;
            spd_reg  <= spd_next;
            head_reg <= heading_error;
        end
        if (b_ready && a_valid_reg)
            b_data_reg <= b_data_next;
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/stanley_cordic_stage.sv -----
// One vectoring CORDIC iteration with its own pipeline register.
`timescale 1ns / 1ps
`default_nettype none

module stanley_cordic_stage
    import stanley_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire cordic_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output cordic_t      out_data
);

    logic                  valid_reg;
    cordic_t               data_reg;
    cordic_t               data_next;
    logic signed [X_W-1:0] xs;
    logic signed [X_W-1:0] ys;
    logic signed [Z_W-1:0] angle;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        xs        = in_data.x >>> STEP;
        ys        = in_data.y >>> STEP;
        angle     = $signed({{(Z_W-17){1'b0}}, ATAN_Q16[STEP]});
        data_next = in_data;
        // rotate toward the x axis: clockwise while y is non-negative
        if (!in_data.y[X_W-1])
        begin
            data_next.x = in_data.x + ys;
            data_next.y = in_data.y - xs;
            data_next.z = in_data.z + angle;
        end
        else
        begin
            data_next.x = in_data.x - ys;
            data_next.y = in_data.y + xs;
            data_next.z = in_data.z - angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/stanley_post.sv -----
// Back end: round the CORDIC angle, restore sign, combine with heading, clamp.
`timescale 1ns / 1ps
`default_nettype none

module stanley_post
    import stanley_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [13:0] limit,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire cordic_t     in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [14:0]      steer_angle
);

    logic                  c_valid_reg;
    logic                  c_ready;
    logic signed [14:0]    angle_reg;
    logic signed [14:0]    angle_next;
    logic signed [15:0]    head_reg;
    logic signed [Z_W-1:0] rounded;
    logic signed [Z_W-1:0] mag;
    logic                  d_valid_reg;
    logic                  d_ready;
    logic signed [14:0]    steer_reg;
    logic signed [14:0]    steer_next;
    logic signed [16:0]    sum;
    logic signed [16:0]    lim;

    assign d_ready  = !d_valid_reg || out_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign in_ready = c_ready;

    always_comb
    begin
        rounded = (in_data.z + 20'sd4) >>> 3;
        if (in_data.zero || in_data.z[Z_W-1])
            mag = '0;
        else if (rounded > HALF_PI_Q13)
            mag = HALF_PI_Q13;
        else
            mag = rounded;
        angle_next = in_data.neg ? -mag[14:0] : mag[14:0];
    end

    always_comb
    begin
        sum = -{head_reg[15], head_reg} - {{2{angle_reg[14]}}, angle_reg};
        lim = $signed({3'b000, limit});
        if (sum > lim)
            steer_next = lim[14:0];
        else if (sum < -lim)
            steer_next = -lim[14:0];
        else
            steer_next = sum[14:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (c_ready)
                c_valid_reg <= in_valid;
            if (d_ready)
                d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && in_valid)
        begin
            angle_reg <= angle_next;
            head_reg  <= in_data.head;
        end
        if (d_ready && c_valid_reg)
            steer_reg <= steer_next;
    end

    assign out_valid   = d_valid_reg;
    assign steer_angle = steer_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/stanley_steering_law_core.sv -----
// Stanley steering law core: top level with configuration registers.
//
// Computes steer = -heading_error - atan2(gain * lateral_error, max(speed, 0.1)),
// clamped to +/- steer_limit, in Q3.13 radians. The datapath is a fully
// pipelined vectoring CORDIC with one register stage per iteration, so the
// core accepts one item every clock cycle unless the output stalls. The
// pipeline has two front-end stages (gain multiply, magnitude), one stage per
// CORDIC iteration, and two back-end stages (rounding, heading sum and clamp).
// Backpressure on the output stalls only full stages; bubbles still close up.
// Write configuration only while the pipeline is empty.
`timescale 1ns / 1ps
`default_nettype none

module stanley_steering_law_core
    import stanley_pkg::*;
#(
    parameter int CORDIC_STEPS = 14
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [15:0] heading_error, [31:16] lateral_error, [47:32] vehicle_speed
    input  wire logic [47:0]            s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [14:0] steer_angle, [15] zero
    output logic [15:0]                 m_tdata,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [15:0] gain_reg;
    logic [13:0] limit_reg;
    logic [14:0] steer_angle;

    cordic_t chain_data  [0:CORDIC_STEPS];
    logic    chain_valid [0:CORDIC_STEPS];
    logic    chain_ready [0:CORDIC_STEPS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= GAIN_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_GAIN:  gain_reg  <= cfg_data;
                REG_LIMIT: limit_reg <= cfg_data[13:0];
                default:   ;
            endcase
        end
    end

    stanley_prep u_prep (
        .clk           (clk),
        .rst_n         (rst_n),
        .gain          (gain_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .heading_error (s_tdata[15:0]),
        .lateral_error (s_tdata[31:16]),
        .vehicle_speed (s_tdata[47:32]),
        .out_valid     (chain_valid[0]),
        .out_ready     (chain_ready[0]),
        .out_data      (chain_data[0])
    );

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        stanley_cordic_stage #(
            .STEP (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    stanley_post u_post (
        .clk         (clk),
        .rst_n       (rst_n),
        .limit       (limit_reg),
        .in_valid    (chain_valid[CORDIC_STEPS]),
        .in_ready    (chain_ready[CORDIC_STEPS]),
        .in_data     (chain_data[CORDIC_STEPS]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .steer_angle (steer_angle)
    );

    assign m_tdata = {1'b0, steer_angle};

    // an empty output stage leaves the whole pipeline free to take an item
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output stage is empty");

    // the floored speed keeps the CORDIC x input strictly positive
    assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[0] |-> (!chain_data[0].x[X_W-1] && chain_data[0].x != '0))
        else $error("CORDIC x input not positive");

    // x only grows through the iterations; a sign flip means overflow
    assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[CORDIC_STEPS] |-> !chain_data[CORDIC_STEPS].x[X_W-1])
        else $error("CORDIC x overflowed");

endmodule

`default_nettype wire
